// ===== hw/rtl/mtfm_pkg.sv =====
// mtfm_pkg: shared codes, character constants and structs of the topic filter matcher
// used by every module under hw/rtl; no dependencies
package mtfm_pkg;

    // default filter store size
    localparam int MAX_FILTER_DEF = 64;

    // input beat actions
    localparam logic [1:0] ACT_FILTER_BYTE = 2'd0;
    localparam logic [1:0] ACT_FILTER_END  = 2'd1;
    localparam logic [1:0] ACT_TOPIC_BYTE  = 2'd2;
    localparam logic [1:0] ACT_TOPIC_END   = 2'd3;

    // special characters
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // fan-in of one or-tree stage
    localparam int TREE_FAN = 8;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic       load_step;    // filter byte beat
        logic       tail_reset;   // a new filter begins, store becomes empty
        logic       topic_step;   // topic byte beat
        logic       restart;      // match walk back to position zero
        logic       eff_restart;  // walk is taken as restarted this cycle
        logic       kill;         // dollar topic against a wildcard first level
        logic [7:0] sym;
    } t_mtfm_bcast;

    // cell to right neighbor
    typedef struct packed {
        logic tail_e;      // effective tail mark of this cell
        logic st;          // level start token for the neighbor
        logic lit;         // literal token for the neighbor
        logic plus_enter;  // plus level entered, neighbor holds the token now
    } t_mtfm_fwd;

    // cell to left neighbor
    typedef struct packed {
        logic is_hash;
        logic is_wild;
        logic tail;
        logic tail_next;   // tail mark of the cell after this one
    } t_mtfm_back;

    // one result beat
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_mtfm_res;

    // number of or-tree stages that bring n bits down to one
    function automatic int tree_depth(input int n);
        int w;
        int d;
        w = n;
        d = 0;
        for (int k = 0; k < 16; k++) begin
            if (w > 1) begin
                w = (w + TREE_FAN - 1) / TREE_FAN;
                d = d + 1;
            end
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/mtfm_cell.sv =====
// mtfm_cell: one filter position, holding its byte, tail mark and match tokens
// depends on mtfm_pkg
module mtfm_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_home,
    input  logic                    i_stop,
    input  mtfm_pkg::t_mtfm_bcast   i_bc,
    input  mtfm_pkg::t_mtfm_fwd     i_left,
    input  mtfm_pkg::t_mtfm_back    i_right,
    output mtfm_pkg::t_mtfm_fwd     o_right,
    output mtfm_pkg::t_mtfm_back    o_left,
    output logic                    o_hit
);
    import mtfm_pkg::*;

    logic [7:0] r_byte;
    logic       r_tail, n_tail;
    logic       r_st, n_st;
    logic       r_lit, n_lit;
    logic       r_plus, n_plus;
    logic       r_hash, n_hash;

    logic w_tail_e;
    logic w_st_e, w_lit_e, w_plus_e, w_hash_e;
    logic w_fi, w_is_slash, w_is_plus, w_is_hash, w_c_slash;
    logic w_enter_hash, w_enter_plus, w_enter_lit;
    logic w_plus_now, w_lit_act, w_lit_ok, w_plus_stay, w_plus_adv;

    // effective tail and tokens for this beat
    assign w_tail_e = i_bc.tail_reset ? i_home : r_tail;
    assign w_st_e   = i_bc.eff_restart ? i_home : r_st;
    assign w_lit_e  = !i_bc.eff_restart && r_lit;
    assign w_plus_e = !i_bc.eff_restart && r_plus;
    assign w_hash_e = !i_bc.eff_restart && r_hash;

    // byte classes, fi means this position holds a filter byte
    assign w_fi       = !r_tail;
    assign w_is_slash = (r_byte == CH_SLASH);
    assign w_is_plus  = (r_byte == CH_PLUS);
    assign w_is_hash  = (r_byte == CH_HASH);
    assign w_c_slash  = (i_bc.sym == CH_SLASH);

    // level entry
    assign w_enter_hash = w_st_e && w_fi && w_is_hash;
    assign w_enter_plus = w_st_e && w_fi && w_is_plus;
    assign w_enter_lit  = w_st_e && !(w_fi && (w_is_hash || w_is_plus));

    // token moves for a topic byte
    assign w_plus_now  = w_plus_e || i_left.plus_enter;
    assign w_lit_act   = w_lit_e || w_enter_lit;
    assign w_lit_ok    = w_lit_act && w_fi && (r_byte == i_bc.sym);
    assign w_plus_stay = w_plus_now && !w_c_slash;
    assign w_plus_adv  = w_plus_now && w_c_slash && w_fi && w_is_slash;

    // neighbor links
    assign o_right.tail_e     = w_tail_e;
    assign o_right.st         = ((w_lit_ok && w_c_slash) || w_plus_adv) && !i_bc.kill;
    assign o_right.lit        = w_lit_ok && !w_c_slash && !i_bc.kill;
    assign o_right.plus_enter = w_enter_plus;

    assign o_left.is_hash   = w_is_hash;
    assign o_left.is_wild   = w_is_hash || w_is_plus;
    assign o_left.tail      = r_tail;
    assign o_left.tail_next = i_right.tail;

    // end-of-topic verdict: hash level, filter end, or a trailing slash-hash
    assign o_hit = w_hash_e || w_enter_hash ||
                   ((w_lit_act || w_plus_now) &&
                    (!w_fi || (w_is_slash && i_right.is_hash && i_right.tail_next)));

    // next tail and tokens
    always_comb begin
        n_tail = r_tail;
        if (i_bc.load_step) begin
            n_tail = i_left.tail_e || (i_stop && w_tail_e);
        end else if (i_bc.tail_reset) begin
            n_tail = i_home;
        end

        n_st   = r_st;
        n_lit  = r_lit;
        n_plus = r_plus;
        n_hash = r_hash;
        if (i_bc.restart) begin
            n_st   = i_home;
            n_lit  = 1'b0;
            n_plus = 1'b0;
            n_hash = 1'b0;
        end else if (i_bc.topic_step) begin
            n_st   = i_left.st;
            n_lit  = i_left.lit;
            n_plus = w_plus_stay && !i_bc.kill;
            n_hash = (w_hash_e || w_enter_hash) && !i_bc.kill;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= i_home;
            r_st   <= i_home;
            r_lit  <= 1'b0;
            r_plus <= 1'b0;
            r_hash <= 1'b0;
        end else begin
            r_tail <= n_tail;
            r_st   <= n_st;
            r_lit  <= n_lit;
            r_plus <= n_plus;
            r_hash <= n_hash;
        end
    end

    // filter byte, written at the tail
    always_ff @(posedge i_clk) begin
        if (i_bc.load_step && w_tail_e && !i_stop) begin
            r_byte <= i_bc.sym;
        end
    end

endmodule

// ===== hw/rtl/mtfm_or_tree.sv =====
// mtfm_or_tree: registered or-reduction of the per-cell verdicts
// depends on mtfm_pkg
module mtfm_or_tree #(
    parameter int N = mtfm_pkg::MAX_FILTER_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [N-1:0]          i_hit,
    input  logic                  i_ovf,
    output logic                  o_vld,
    output mtfm_pkg::t_mtfm_res   o_res
);
    import mtfm_pkg::*;

    localparam int L  = tree_depth(N);
    localparam int PW = TREE_FAN * ((N + TREE_FAN - 1) / TREE_FAN);

    logic [PW-1:0] r_lvl [0:L];
    logic [PW-1:0] n_lvl [1:L];
    logic [L:0]    r_vld;
    logic [L:0]    r_ovf;

    // each stage ors groups of TREE_FAN bits
    always_comb begin
        for (int k = 1; k <= L; k++) begin
            n_lvl[k] = '0;
            for (int j = 0; j < PW / TREE_FAN; j++) begin
                n_lvl[k][j] = |r_lvl[k-1][TREE_FAN*j +: TREE_FAN];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        r_lvl[0] <= PW'(i_hit);
        for (int k = 1; k <= L; k++) begin
            r_lvl[k] <= n_lvl[k];
        end
        r_ovf <= {r_ovf[L-1:0], i_ovf};
    end

    // beat tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[L-1:0], i_vld};
        end
    end

    assign o_vld          = r_vld[L];
    assign o_res.matched  = r_lvl[L][0];
    assign o_res.overflow = r_ovf[L];

endmodule

// ===== hw/rtl/mtfm_res_fifo.sv =====
// mtfm_res_fifo: small result queue in front of the output channel
// depends on mtfm_pkg
module mtfm_res_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mtfm_pkg::t_mtfm_res   i_res,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mtfm_pkg::t_mtfm_res   o_res
);
    import mtfm_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_mtfm_res       r_mem [0:DEPTH-1];
    logic [PTRW-1:0] r_wr, n_wr;
    logic [PTRW-1:0] r_rd, n_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    // pointers with wrap at DEPTH
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_cnt = r_cnt + CNTW'(i_push) - CNTW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

// ===== hw/rtl/mqtt_topic_filter_matcher_unit.sv =====
// mqtt_topic_filter_matcher_unit: top level, filter load checks and the cell row
// depends on mtfm_pkg, mtfm_cell, mtfm_or_tree, mtfm_res_fifo
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries i_action and i_symbol. A filter is
//   loaded as filter-byte beats closed by an end-of-filter beat; topics follow as
//   topic-byte beats closed by an end-of-topic beat. Only end-of-topic beats make a
//   result beat on the output channel (o_out_valid / i_out_ready) with o_matched and
//   o_filter_overflow.
//   Throughput: one input beat per cycle, every action, while o_in_ready is high. The filter
//   lives in a row of MAX_FILTER+1 cells; the match position is a token handed from cell
//   to cell, so the filter contents never slow a topic byte.
//   Result path: an end-of-topic verdict passes the verdict register, one stage per 8:1
//   or-tree level and then the result queue before it shows on o_out_valid.
//   Stall: results queue in a small fifo sized for the tree; o_in_ready drops only when
//   tree_depth+3 results are outstanding, so the input keeps flowing while a result
//   waits on a stalled receiver.
//   Reset: synchronous, active low; the filter becomes empty, so nothing matches until
//   a filter is loaded, and the result queue empties.
module mqtt_topic_filter_matcher_unit #(
    parameter int MAX_FILTER = mtfm_pkg::MAX_FILTER_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_symbol,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_filter_overflow
);
    import mtfm_pkg::*;

    localparam int         N       = MAX_FILTER + 1;
    localparam int         L       = tree_depth(N);
    localparam int         CAP     = L + 3;
    localparam int         CW      = $clog2(CAP + 1);
    localparam logic [1:0] LVL_SAT = 2'd2;

    // filter load state
    logic       r_loading, n_loading;
    logic       r_bad, n_bad;
    logic       r_ovf, n_ovf;
    logic [1:0] r_lvl_cnt, n_lvl_cnt;
    logic       r_lvl_wild, n_lvl_wild;
    logic       r_hash_seen, n_hash_seen;
    logic       r_first, n_first;
    logic [CW-1:0] r_credit, n_credit;

    logic w_in_acc, w_out_acc, w_end_acc;
    logic w_begin, w_finish, w_tail_max, w_kill, w_ok;

    t_mtfm_bcast w_bc;
    t_mtfm_fwd   w_fwd  [0:N];
    t_mtfm_back  w_back [0:N];
    logic [N-1:0] w_hit;

    t_mtfm_res w_tree_res, w_out_res;
    logic      w_tree_vld;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_end_acc = w_in_acc && (i_action == ACT_TOPIC_END);

    assign w_begin    = w_in_acc && !r_loading &&
                        ((i_action == ACT_FILTER_BYTE) || (i_action == ACT_FILTER_END));
    assign w_finish   = w_in_acc && (i_action != ACT_FILTER_BYTE) &&
                        (r_loading || (i_action == ACT_FILTER_END));
    assign w_tail_max = !w_begin && w_back[N-1].tail;

    // level checks while loading, then closing the filter
    always_comb begin
        n_loading   = r_loading;
        n_bad       = r_bad;
        n_ovf       = r_ovf;
        n_lvl_cnt   = r_lvl_cnt;
        n_lvl_wild  = r_lvl_wild;
        n_hash_seen = r_hash_seen;
        n_first     = r_first;
        if (w_begin) begin
            n_bad       = 1'b0;
            n_ovf       = 1'b0;
            n_lvl_cnt   = '0;
            n_lvl_wild  = 1'b0;
            n_hash_seen = 1'b0;
        end
        if (w_in_acc) begin
            case (i_action)
                ACT_FILTER_BYTE: begin
                    n_loading = 1'b1;
                    if (w_tail_max) begin
                        n_ovf = 1'b1;
                    end
                    if (i_symbol == CH_SLASH) begin
                        if ((n_lvl_wild && n_lvl_cnt != 2'd1) || n_hash_seen) begin
                            n_bad = 1'b1;
                        end
                        n_lvl_cnt   = '0;
                        n_lvl_wild  = 1'b0;
                        n_hash_seen = 1'b0;
                    end else begin
                        if (n_lvl_cnt != LVL_SAT) begin
                            n_lvl_cnt = n_lvl_cnt + 2'd1;
                        end
                        if ((i_symbol == CH_PLUS) || (i_symbol == CH_HASH)) begin
                            n_lvl_wild = 1'b1;
                        end
                        if (i_symbol == CH_HASH) begin
                            n_hash_seen = 1'b1;
                        end
                    end
                end
                ACT_TOPIC_BYTE: begin
                    n_first = 1'b0;
                end
                default: begin
                    n_first = 1'b1;
                end
            endcase
        end
        if (w_finish) begin
            if (n_lvl_wild && n_lvl_cnt != 2'd1) begin
                n_bad = 1'b1;
            end
            n_lvl_cnt   = '0;
            n_lvl_wild  = 1'b0;
            n_hash_seen = 1'b0;
            n_loading   = 1'b0;
        end
    end

    // dollar topics never match a wildcard first level
    assign w_kill = (i_symbol == CH_DOLLAR) && (r_loading || r_first) &&
                    !w_back[0].tail && w_back[0].is_wild;

    // broadcast to the cell row
    assign w_bc.load_step   = w_in_acc && (i_action == ACT_FILTER_BYTE);
    assign w_bc.tail_reset  = w_begin;
    assign w_bc.topic_step  = w_in_acc && (i_action == ACT_TOPIC_BYTE);
    assign w_bc.restart     = w_in_acc &&
                              ((i_action == ACT_FILTER_END) || (i_action == ACT_TOPIC_END));
    assign w_bc.eff_restart = r_loading;
    assign w_bc.kill        = w_kill;
    assign w_bc.sym         = i_symbol;

    assign w_fwd[0]  = '0;
    assign w_back[N] = '0;

    // row of cells, the last one marks a full store
    for (genvar i = 0; i < N; i++) begin : g_cell
        mtfm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_home  (1'(i == 0)),
            .i_stop  (1'(i == N - 1)),
            .i_bc    (w_bc),
            .i_left  (w_fwd[i]),
            .i_right (w_back[i+1]),
            .o_right (w_fwd[i+1]),
            .o_left  (w_back[i]),
            .o_hit   (w_hit[i])
        );
    end

    // an empty, malformed or overflowing filter never matches
    assign w_ok = !w_back[0].tail && !n_bad && !r_ovf;

    mtfm_or_tree #(
        .N (N)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_end_acc),
        .i_hit   (w_hit & {N{w_ok}}),
        .i_ovf   (r_ovf),
        .o_vld   (w_tree_vld),
        .o_res   (w_tree_res)
    );

    mtfm_res_fifo #(
        .DEPTH (CAP)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_tree_vld),
        .i_res   (w_tree_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_out_res)
    );

    assign o_matched         = w_out_res.matched;
    assign o_filter_overflow = w_out_res.overflow;

    // results in the tree or the queue
    assign n_credit   = r_credit + CW'(w_end_acc) - CW'(w_out_acc);
    assign o_in_ready = (r_credit < CW'(CAP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading   <= 1'b0;
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_lvl_cnt   <= '0;
            r_lvl_wild  <= 1'b0;
            r_hash_seen <= 1'b0;
            r_first     <= 1'b1;
            r_credit    <= '0;
        end else begin
            r_loading   <= n_loading;
            r_bad       <= n_bad;
            r_ovf       <= n_ovf;
            r_lvl_cnt   <= n_lvl_cnt;
            r_lvl_wild  <= n_lvl_wild;
            r_hash_seen <= n_hash_seen;
            r_first     <= n_first;
            r_credit    <= n_credit;
        end
    end

endmodule

// ===== hw/rtl/mtfm_checker.sv =====
// mtfm_checker: port-level checks of the topic filter matcher, bound to the top level
// depends on mtfm_pkg and the mqtt_topic_filter_matcher_unit ports only
module mtfm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_action,
    input logic [7:0] i_symbol,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_matched,
    input logic       o_filter_overflow
);
    import mtfm_pkg::*;

    logic [7:0] r_pend;
    logic       w_end_beat;
    logic       w_out_beat;

    assign w_end_beat = i_in_valid && o_in_ready && (i_action == ACT_TOPIC_END);
    assign w_out_beat = o_out_valid && i_out_ready;

    // end-of-topic beats not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 8'(w_end_beat) - 8'(w_out_beat);
        end
    end

    // no result without an end-of-topic beat waiting for it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result beat without a pending end of topic");

    // queue empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an overflowing filter never reports a match
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_filter_overflow) |-> !o_matched)
        else $error("match reported with filter overflow");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_matched) && $stable(o_filter_overflow)))
        else $error("stalled result beat changed");

endmodule

bind mqtt_topic_filter_matcher_unit mtfm_checker u_mtfm_checker (.*);
